/* hdl/assert_macros.svh */
// Assertion macros shared by the files of the centre line rasteriser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, and switched off while reset is held.
`define CLR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define CLR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/clr_pkg.sv */
// Package of the centre line rasteriser: sizes, register indexes and control types.
package clr_pkg;

  localparam int COORD_BITS     = 6;
  localparam int MAX_RESULTS    = 64;
  localparam int CENTER_X_RESET = 28;
  localparam int CENTER_Y_RESET = 13;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CNT_BITS       = $clog2(MAX_RESULTS);
  localparam int DIV_CNT_BITS   = $clog2(COORD_BITS);

  typedef logic [COORD_BITS-1:0]   coord_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_CENTER_X = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_CENTER_Y = cfg_idx_t'(1);

  typedef struct packed {
    logic load;
    logic div_step;
    logic setup;
    logic advance;
  } clr_cmd_t;

  typedef struct packed {
    logic last;
  } clr_status_t;

endpackage

/* hdl/clr_ifs.sv */
// Channel interfaces of the centre line rasteriser: configuration, endpoint and pixel.
interface clr_cfg_if;
  logic                valid;
  logic                ready;
  clr_pkg::cfg_idx_t   index;
  clr_pkg::coord_t     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface clr_in_if;
  logic            valid;
  logic            ready;
  logic            func;
  clr_pkg::coord_t end_x;
  clr_pkg::coord_t end_y;
  modport source (output valid, func, end_x, end_y, input ready);
  modport sink (input valid, func, end_x, end_y, output ready);
endinterface

interface clr_out_if;
  logic            valid;
  logic            ready;
  clr_pkg::coord_t pixel_x;
  clr_pkg::coord_t pixel_y;
  logic            last_pixel;
  logic            degenerate;
  modport source (output valid, pixel_x, pixel_y, last_pixel, degenerate, input ready);
  modport sink (input valid, pixel_x, pixel_y, last_pixel, degenerate, output ready);
endinterface

/* hdl/clr_ctrl.sv */
// Controller of the centre line rasteriser: sequences load, division, set-up and pixel run.
module clr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  clr_pkg::clr_status_t status,
  output clr_pkg::clr_cmd_t    cmd
);
  import clr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_RUN
  } state_t;

  state_t                  state_r;
  logic                    in_ready_r;
  logic                    out_valid_r;
  logic [DIV_CNT_BITS-1:0] div_cnt_r;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == ST_IDLE) && in_valid && in_ready_r;
    cmd.div_step = (state_r == ST_DIV);
    cmd.setup    = (state_r == ST_SETUP);
    cmd.advance  = (state_r == ST_RUN) && out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd.load) begin
            state_r    <= ST_DIV;
            in_ready_r <= 1'b0;
            div_cnt_r  <= '0;
          end
        end
        ST_DIV: begin
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == DIV_CNT_BITS'(COORD_BITS - 1)) begin
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          state_r     <= ST_RUN;
          out_valid_r <= 1'b1;
        end
        ST_RUN: begin
          if (cmd.advance && status.last) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b0;
            in_ready_r  <= 1'b1;
          end
        end
        default: begin
          state_r     <= ST_IDLE;
          in_ready_r  <= 1'b1;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

/* hdl/clr_datapath.sv */
// Datapath of the centre line rasteriser: centre registers, slope divider and pixel stepper.
module clr_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  clr_pkg::clr_cmd_t    cmd,
  input  logic                 cfg_we,
  input  clr_pkg::cfg_idx_t    cfg_idx,
  input  clr_pkg::coord_t      cfg_data,
  input  logic                 in_func,
  input  clr_pkg::coord_t      in_end_x,
  input  clr_pkg::coord_t      in_end_y,
  output clr_pkg::coord_t      pixel_x,
  output clr_pkg::coord_t      pixel_y,
  output logic                 last_pixel,
  output logic                 degenerate,
  output clr_pkg::clr_status_t status
);
  import clr_pkg::*;

  coord_t center_x_r;
  coord_t center_y_r;

  // Line set-up, taken when the endpoint beat is accepted.
  logic   axis_r;
  logic   degen_r;
  logic   neg_r;
  coord_t major_r;
  coord_t stop_r;
  coord_t minor_r;
  coord_t dmaj_r;

  // Restoring divider: div_q_r holds |dmin| and fills with the quotient.
  coord_t div_q_r;
  coord_t div_rem_r;

  // Stepper: minor_r moves by q_step_r plus a carry when the remainder wraps.
  coord_t                q_step_r;
  logic [COORD_BITS:0]   r_step_r;
  logic [COORD_BITS:0]   r_r;
  logic [CNT_BITS-1:0]   count_r;

  coord_t c_maj, c_min, e_maj, e_min;
  coord_t s_maj, s_stop, s_min, o_min;
  logic   swap, d_neg;
  coord_t d_abs;

  logic [COORD_BITS:0]   partial;
  logic                  ge;
  logic [COORD_BITS:0]   part_diff;

  logic                  rnz;
  logic [COORD_BITS+1:0] r_sum;
  logic [COORD_BITS+1:0] two_dmaj;
  logic [COORD_BITS+1:0] r_wrapped;
  logic                  wrap;
  logic                  last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= COORD_BITS'(CENTER_X_RESET);
      center_y_r <= COORD_BITS'(CENTER_Y_RESET);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_CENTER_X: center_x_r <= cfg_data;
        CFG_CENTER_Y: center_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    c_maj  = in_func ? center_x_r : center_y_r;
    c_min  = in_func ? center_y_r : center_x_r;
    e_maj  = in_func ? in_end_x : in_end_y;
    e_min  = in_func ? in_end_y : in_end_x;
    swap   = e_maj < c_maj;
    s_maj  = swap ? e_maj : c_maj;
    s_stop = swap ? c_maj : e_maj;
    s_min  = swap ? e_min : c_min;
    o_min  = swap ? c_min : e_min;
    d_neg  = o_min < s_min;
    d_abs  = d_neg ? (s_min - o_min) : (o_min - s_min);
  end

  always_comb begin
    partial   = {div_rem_r, div_q_r[COORD_BITS-1]};
    part_diff = partial - {1'b0, dmaj_r};
    ge        = partial >= {1'b0, dmaj_r};
  end

  always_comb begin
    rnz       = |div_rem_r;
    r_sum     = {1'b0, r_r} + {1'b0, r_step_r};
    two_dmaj  = {1'b0, dmaj_r, 1'b0};
    wrap      = r_sum >= two_dmaj;
    r_wrapped = r_sum - two_dmaj;
    last      = degen_r || (major_r == stop_r) ||
                (count_r == CNT_BITS'(MAX_RESULTS - 1));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      axis_r    <= in_func;
      degen_r   <= (e_maj == c_maj);
      neg_r     <= d_neg;
      major_r   <= s_maj;
      stop_r    <= s_stop;
      minor_r   <= s_min;
      dmaj_r    <= s_stop - s_maj;
      div_q_r   <= d_abs;
      div_rem_r <= '0;
    end else if (cmd.div_step) begin
      div_rem_r <= ge ? part_diff[COORD_BITS-1:0] : partial[COORD_BITS-1:0];
      div_q_r   <= {div_q_r[COORD_BITS-2:0], ge};
    end else if (cmd.setup) begin
      // Floor division of a negative minor difference rounds the quotient down.
      if (!neg_r) begin
        q_step_r <= div_q_r;
        r_step_r <= {div_rem_r, 1'b0};
      end else if (rnz) begin
        q_step_r <= ~div_q_r;
        r_step_r <= {dmaj_r - div_rem_r, 1'b0};
      end else begin
        q_step_r <= -div_q_r;
        r_step_r <= '0;
      end
      r_r     <= {1'b0, dmaj_r};
      count_r <= '0;
    end else if (cmd.advance) begin
      r_r     <= wrap ? r_wrapped[COORD_BITS:0] : r_sum[COORD_BITS:0];
      minor_r <= minor_r + q_step_r + COORD_BITS'(wrap);
      major_r <= major_r + 1'b1;
      count_r <= count_r + 1'b1;
    end
  end

  assign pixel_x     = axis_r ? major_r : minor_r;
  assign pixel_y     = axis_r ? minor_r : major_r;
  assign last_pixel  = last;
  assign degenerate  = degen_r;
  assign status.last = last;

endmodule

/* hdl/center_line_rasterizer.sv */
// Centre line rasteriser top level: channels, controller and datapath.
// An accepted endpoint passes through the slope divider and a set-up state before its first pixel beat.
// The slope divider produces one quotient bit per cycle, followed by the set-up state.
// Pixels then leave at one per cycle while the sink is ready; the next endpoint is taken after the last beat.
// A zero major extent yields one flagged centre pixel after the same divider and set-up states.
// Synchronous active-low reset idles the block and sets the centre to column 28, row 13.
`include "assert_macros.svh"

module center_line_rasterizer (
  input logic       clk,
  input logic       rst_n,
  clr_cfg_if.sink   cfg_ch,
  clr_in_if.sink    in_ch,
  clr_out_if.source out_ch
);
  import clr_pkg::*;

  clr_cmd_t    cmd;
  clr_status_t status;

  assign cfg_ch.ready = 1'b1;

  clr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  clr_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg_we     (cfg_ch.valid),
    .cfg_idx    (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .in_func    (in_ch.func),
    .in_end_x   (in_ch.end_x),
    .in_end_y   (in_ch.end_y),
    .pixel_x    (out_ch.pixel_x),
    .pixel_y    (out_ch.pixel_y),
    .last_pixel (out_ch.last_pixel),
    .degenerate (out_ch.degenerate),
    .status     (status)
  );

  `CLR_ASSERT(a_no_accept_in_run, (in_ch.valid && in_ch.ready) |-> !out_ch.valid, "endpoint accepted while pixels pending")
  `CLR_ASSERT(a_degen_single, (out_ch.valid && out_ch.degenerate) |-> out_ch.last_pixel, "degenerate pixel not marked last")
  `CLR_ASSERT(a_last_ends_run, (out_ch.valid && out_ch.ready && out_ch.last_pixel) |=> (!out_ch.valid && in_ch.ready), "run did not end after last beat")
  `CLR_ASSERT(a_cmd_onehot, $onehot0({cmd.load, cmd.div_step, cmd.setup, cmd.advance}), "controller issued overlapping commands")

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the centre line rasteriser: predicted pixel runs against DUT output.
`timescale 1ns / 1ps

module testbench;
  import clr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
    logic   degen;
  } pixel_t;

  // Tracks the centre registers and predicts the pixel run of every accepted endpoint.
  class line_predictor;
    coord_t center_x;
    coord_t center_y;
    pixel_t pending_pixels[$];
    int     lines;
    int     degenerate_lines;
    int     pixels;
    int     errors;

    function new();
      center_x = coord_t'(CENTER_X_RESET);
      center_y = coord_t'(CENTER_Y_RESET);
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    function void note_endpoint(logic axis, coord_t ex, coord_t ey);
      int     cmaj, cmin, emaj, emin, smin, start, dmaj, dmin, num, den, q;
      pixel_t p;
      lines++;
      if (axis) begin
        cmaj = center_x; cmin = center_y; emaj = ex; emin = ey;
      end else begin
        cmaj = center_y; cmin = center_x; emaj = ey; emin = ex;
      end
      if (emaj == cmaj) begin
        p = '{center_x, center_y, 1'b1, 1'b1};
        pending_pixels.push_back(p);
        degenerate_lines++;
        return;
      end
      // The run always climbs the major axis, so a lower endpoint becomes the start.
      if (emaj < cmaj) begin
        start = emaj; smin = emin; dmaj = cmaj - emaj; dmin = cmin - emin;
      end else begin
        start = cmaj; smin = cmin; dmaj = emaj - cmaj; dmin = emin - cmin;
      end
      den = 2 * dmaj;
      for (int k = 0; k <= dmaj && k < MAX_RESULTS; k++) begin
        // Round to nearest with halves upwards: floor((2*dm*k + dM) / (2*dM)).
        num = 2 * dmin * k + dmaj;
        q = num / den;
        if (num < 0 && (num % den) != 0) q--;
        p.last = (k == dmaj) || (k == MAX_RESULTS - 1);
        p.degen = 1'b0;
        if (axis) begin
          p.x = coord_t'(start + k);
          p.y = coord_t'(smin + q);
        end else begin
          p.x = coord_t'(smin + q);
          p.y = coord_t'(start + k);
        end
        pending_pixels.push_back(p);
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel x=%0d y=%0d last=%0b degenerate=%0b",
                 $time, got.x, got.y, got.last, got.degen);
        return;
      end
      want = pending_pixels.pop_front();
      pixels++;
      if (got.x !== want.x || got.y !== want.y || got.last !== want.last ||
          got.degen !== want.degen) begin
        errors++;
        $display("%0t: pixel mismatch: expected x=%0d y=%0d last=%0b degenerate=%0b",
                 $time, want.x, want.y, want.last, want.degen);
        $display("%0t:                  actual x=%0d y=%0d last=%0b degenerate=%0b",
                 $time, got.x, got.y, got.last, got.degen);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycles;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_requests;
  int   hold_served;
  int   hold_left;
  int   centre_settings;

  line_predictor lp = new();

  clr_cfg_if cfg_ch ();
  clr_in_if  in_ch ();
  clr_out_if out_ch ();

  center_line_rasterizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d pixels outstanding", cycles, lp.pending());
      $display("FAILURE");
      $finish;
    end
  end

  // Pixel sink: checks each beat and drives ready, with a long hold-off when one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        lp.check_pixel('{out_ch.pixel_x, out_ch.pixel_y, out_ch.last_pixel, out_ch.degenerate});
      end
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic configure(coord_t cx, coord_t cy);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_CENTER_X;
    cfg_ch.data  <= cx;
    do @(posedge clk); while (!cfg_ch.ready);
    lp.center_x = cx;
    cfg_ch.index <= CFG_CENTER_Y;
    cfg_ch.data  <= cy;
    do @(posedge clk); while (!cfg_ch.ready);
    lp.center_y = cy;
    cfg_ch.valid <= 1'b0;
    centre_settings++;
  endtask

  // Valid is only lowered during an idle gap, so back-to-back beats keep it high.
  task automatic send_endpoint(logic axis, coord_t ex, coord_t ey);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= axis;
    in_ch.end_x <= ex;
    in_ch.end_y <= ey;
    do @(posedge clk); while (!in_ch.ready);
    lp.note_endpoint(axis, ex, ey);
  endtask

  task automatic random_endpoint();
    int     pick;
    logic   axis;
    coord_t ex, ey;
    pick = $urandom_range(99);
    axis = 1'($urandom_range(1));
    ex = coord_t'($urandom);
    ey = coord_t'($urandom);
    if (pick < 12) begin
      if (axis) ex = lp.center_x;
      else ey = lp.center_y;
    end else if (pick < 35) begin
      ex = coord_t'(lp.center_x + $urandom_range(8) - 4);
      ey = coord_t'(lp.center_y + $urandom_range(8) - 4);
    end
    send_endpoint(axis, ex, ey);
  endtask

  task automatic settle();
    while (lp.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int cfg_x[9] = '{0, 63, -1, 63, 0, -1, 28, -1, -1};
    int cfg_y[9] = '{0, 63, -1, 0, 63, -1, 13, -1, -1};
    int sel;
    rst_n = 1'b0;
    hold_requests = 0;
    centre_settings = 0;
    send_idle_pct = 23;
    recv_idle_pct = 75;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_CENTER_X;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.func = 1'b0;
    in_ch.end_x = '0;
    in_ch.end_y = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines from the reset centre: zero extents, corners, swaps, exact halves.
    send_endpoint(1'b1, 6'd28, 6'd40);
    send_endpoint(1'b0, 6'd5, 6'd13);
    send_endpoint(1'b0, 6'd28, 6'd13);
    send_endpoint(1'b1, 6'd63, 6'd63);
    send_endpoint(1'b1, 6'd0, 6'd0);
    send_endpoint(1'b0, 6'd0, 6'd63);
    send_endpoint(1'b0, 6'd63, 6'd0);
    send_endpoint(1'b1, 6'd30, 6'd14);
    send_endpoint(1'b1, 6'd30, 6'd12);
    send_endpoint(1'b1, 6'd29, 6'd63);
    send_endpoint(1'b0, 6'd0, 6'd14);
    send_endpoint(1'b1, 6'd27, 6'd13);
    in_ch.valid <= 1'b0;
    settle();
    configure(6'd0, 6'd0);
    send_endpoint(1'b1, 6'd63, 6'd63);
    send_endpoint(1'b0, 6'd63, 6'd63);
    send_endpoint(1'b0, 6'd63, 6'd0);
    send_endpoint(1'b1, 6'd0, 6'd63);
    in_ch.valid <= 1'b0;
    settle();
    configure(6'd63, 6'd63);
    send_endpoint(1'b1, 6'd0, 6'd0);
    send_endpoint(1'b0, 6'd0, 6'd0);
    send_endpoint(1'b1, 6'd63, 6'd0);
    send_endpoint(1'b0, 6'd0, 6'd63);
    in_ch.valid <= 1'b0;

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 23; recv_idle_pct = 75;
        end
        1: begin
          send_idle_pct = 75; recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0; recv_idle_pct = 0;
        end
      endcase
      for (int sub = 0; sub < 3; sub++) begin
        sel = mode * 3 + sub;
        settle();
        configure(coord_t'(cfg_x[sel] < 0 ? $urandom_range(63) : cfg_x[sel]),
                  coord_t'(cfg_y[sel] < 0 ? $urandom_range(63) : cfg_y[sel]));
        // With no idling the sink stalls for a long stretch so the block backs up.
        if (mode == 2 && sub == 0) hold_requests++;
        repeat (26) random_endpoint();
        in_ch.valid <= 1'b0;
      end
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Rasterised %0d lines (%0d with zero major extent) into %0d checked pixel beats,",
             lp.lines, lp.degenerate_lines, lp.pixels);
    $display("over %0d centre settings including all four corners; %0d mismatches.",
             centre_settings, lp.errors);
    if (lp.errors == 0 && lp.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
